// ===== hw/rtl/quote_level_change_amplifier_core_macros.svh =====
// Assertion macros for the quote level change amplifier checker.
// Included by the checker file only.
`ifndef QUOTE_LEVEL_CHANGE_AMPLIFIER_CORE_MACROS_SVH
`define QUOTE_LEVEL_CHANGE_AMPLIFIER_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define QLCA_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define QLCA_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/qlca_pkg.sv =====
// Package for the quote level change amplifier: types and constants.
// No dependencies.
package qlca_pkg;
  localparam int unsigned PriceW = 48;
  localparam int unsigned SizeW = 32;
  localparam int unsigned TickW = 32;
  localparam int unsigned TimeW = 27;
  localparam int unsigned CfgW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam logic signed [TickW-1:0] ResetTick = -32'sd1000;
  localparam logic [15:0] MinStabMs = 16'd20;

  localparam logic [CfgIdxW-1:0] RegStability = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGrowth = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDepletion = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpread = 2'd3;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic signed [TickW-1:0] tick;
    logic [TimeW-1:0] tm;
  } quote_t;

  typedef struct packed {
    logic action;
    logic view_ready;
    logic [SizeW-1:0] bid_size;
    logic signed [TickW-1:0] bid_tick;
    logic [SizeW-1:0] ask_size;
    logic signed [TickW-1:0] ask_tick;
    logic signed [PriceW-1:0] bid_price;
    logic signed [PriceW-1:0] ask_price;
    logic signed [PriceW-1:0] weighted_price;
    logic [TimeW-1:0] time_ms;
  } update_t;

  typedef struct packed {
    logic signed [PriceW-1:0] indicator;
  } result_t;
endpackage

// ===== hw/rtl/qlca_if.sv =====
// Valid/ready channel carrying one payload.
// Payload type set by the payload_t parameter.
interface qlca_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/qlca_side.sv =====
// One side's quote ring with head/tail and a serial age walk.
// Depends on qlca_pkg.
module qlca_side
  import qlca_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 10,
  parameter bit IS_BID = 1'b1
) (
  input logic clk,
  input logic rst,
  input logic start,
  input quote_t newq,
  input logic [15:0] stab,
  input logic finish,
  output logic done,
  output quote_t tail_q,
  output quote_t head_q,
  output quote_t prev_q,
  output logic multi
);
  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IW-1:0] Last = IW'(RING_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_CHK = 4'b0010, S_WALK = 4'b0100, S_DONE = 4'b1000
  } sstate_t;

  quote_t ring [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld;
  logic [IW-1:0] head, tail;
  sstate_t state;

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] i);
    return (i == Last) ? '0 : i + 1'b1;
  endfunction

  logic [IW-1:0] prev;
  quote_t rd_head, rd_prev;
  logic signed [TimeW:0] age;
  logic signed [TickW:0] dt;
  logic worse;

  assign prev = (tail == '0) ? Last : tail - 1'b1;
  assign rd_head = vld[head] ? ring[head] : '{size: '0, tick: ResetTick, tm: '0};
  assign rd_prev = vld[prev] ? ring[prev] : '{size: '0, tick: ResetTick, tm: '0};
  assign tail_q = ring[tail];
  assign head_q = (head == tail) ? ring[tail] : rd_head;
  assign prev_q = rd_prev;
  assign multi = (head != tail);
  assign done = (state == S_DONE);
  assign age = $signed({1'b0, ring[tail].tm}) - $signed({1'b0, rd_head.tm});
  assign dt = IS_BID ? ($signed({ring[tail].tick[TickW-1], ring[tail].tick})
                        - $signed({rd_prev.tick[TickW-1], rd_prev.tick}))
                     : ($signed({rd_prev.tick[TickW-1], rd_prev.tick})
                        - $signed({ring[tail].tick[TickW-1], ring[tail].tick}));
  assign worse = dt[TickW] || (dt == '0 && ring[tail].size < rd_prev.size);

  always_ff @(posedge clk) begin
    if (start) ring[tail] <= newq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      tail <= '0;
      vld <= '0;
    end else begin
      case (state)
        S_IDLE: if (start) begin
          vld[tail] <= 1'b1;
          state <= S_CHK;
        end
        S_CHK: begin
          if (head != tail && worse) head <= tail;
          state <= S_WALK;
        end
        S_WALK: begin
          if (head != tail && age > $signed({12'd0, stab})) head <= inc(head);
          else state <= S_DONE;
        end
        S_DONE: if (finish) begin
          tail <= inc(tail);
          if (inc(tail) == head) head <= inc(head);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/quote_level_change_amplifier_core.sv =====
// Quote level change amplifier: serial age walk on two rings, then result.
// Steps: take the update (T_IDLE), age walk (T_WALK), c (T_MUL), saturate (T_RES),
// hand out (T_OUT). The age walk drops one entry per cycle, at most RING_DEPTH-1 per
// side, both sides walking in parallel. An interrupt goes straight to T_OUT with a zero
// result; an unarmed update gives no result, it arms the block if view_ready is set.
// Not ready while busy. Sync reset clears ring valid bits, pointers, armed and state.
module quote_level_change_amplifier_core
  import qlca_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 10
) (
  input logic clk,
  input logic rst,
  qlca_if.sink in_ch,
  qlca_if.source out_ch,
  input logic cfg_we,
  input logic [CfgIdxW-1:0] cfg_index,
  input logic [CfgW-1:0] cfg_data
);
  typedef enum logic [4:0] {
    T_IDLE = 5'b00001, T_WALK = 5'b00010, T_MUL = 5'b00100,
    T_RES = 5'b01000, T_OUT = 5'b10000
  } tstate_t;

  tstate_t state;
  logic [15:0] stability_ms, spread_fraction;
  logic [31:0] growth_size, depletion_size;
  logic armed;
  update_t u;
  logic signed [PriceW-1:0] res;
  logic signed [65:0] c;

  always_ff @(posedge clk) begin
    if (rst) begin
      stability_ms <= 16'd1000;
      growth_size <= '0;
      depletion_size <= '0;
      spread_fraction <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        RegStability: stability_ms <= cfg_data[15:0];
        RegGrowth: growth_size <= cfg_data;
        RegDepletion: depletion_size <= cfg_data;
        RegSpread: spread_fraction <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0] stab;
  assign stab = (stability_ms < MinStabMs) ? MinStabMs : stability_ms;

  logic go, fin;
  logic bdone, adone, bmulti, amulti;
  quote_t bt, bh, bp, at, ah, ap;
  assign go = in_ch.valid && in_ch.ready && !in_ch.data.action && armed;
  assign fin = (state == T_OUT) && out_ch.ready;

  qlca_side #(.RING_DEPTH(RING_DEPTH), .IS_BID(1'b1)) u_bid (
    .clk, .rst, .start(go),
    .newq('{size: in_ch.data.bid_size, tick: in_ch.data.bid_tick, tm: in_ch.data.time_ms}),
    .stab, .finish(fin), .done(bdone), .tail_q(bt), .head_q(bh), .prev_q(bp),
    .multi(bmulti));
  qlca_side #(.RING_DEPTH(RING_DEPTH), .IS_BID(1'b0)) u_ask (
    .clk, .rst, .start(go),
    .newq('{size: in_ch.data.ask_size, tick: in_ch.data.ask_tick, tm: in_ch.data.time_ms}),
    .stab, .finish(fin), .done(adone), .tail_q(at), .head_q(ah), .prev_q(ap),
    .multi(amulti));

  // spread and c, one product of 49x17
  logic signed [PriceW:0] spread;
  logic signed [65:0] prod;
  assign spread = $signed({u.ask_price[PriceW-1], u.ask_price})
                - $signed({u.bid_price[PriceW-1], u.bid_price});
  assign prod = 66'(spread * $signed({1'b0, spread_fraction}));

  logic signed [65:0] bp64, ap64, wp64, r_bu, r_au, r_bd, r_ad, r_sel;
  logic bid_up, ask_up, bdep, adep;
  assign bp64 = 66'(u.bid_price);
  assign ap64 = 66'(u.ask_price);
  assign wp64 = 66'(u.weighted_price);
  assign bid_up = (bt.tick > bh.tick) && (wp64 - bp64 < c) && (bt.size > growth_size);
  assign ask_up = (at.tick < ah.tick) && (ap64 - wp64 < c) && (at.size > growth_size);
  assign bdep = bmulti && bt.tick == bp.tick && bt.size <= bp.size
                && bt.size < depletion_size;
  assign adep = amulti && at.tick == ap.tick && at.size <= ap.size
                && at.size < depletion_size;
  assign r_bu = bp64 + c - wp64;
  assign r_au = ap64 - c - wp64;
  assign r_bd = bp64 - wp64;
  assign r_ad = ap64 - wp64;

  always_comb begin
    r_sel = '0;
    if (bid_up && !ask_up) r_sel = r_bu[65] ? '0 : r_bu;
    else if (ask_up && !bid_up) r_sel = r_au[65] ? r_au : '0;
    else if (!bid_up && !ask_up) begin
      if (bdep) r_sel = r_bd;
      else if (adep) r_sel = r_ad;
    end
  end

  assign in_ch.ready = (state == T_IDLE);
  assign out_ch.valid = (state == T_OUT);
  assign out_ch.data.indicator = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      armed <= 1'b0;
    end else begin
      case (state)
        T_IDLE: if (in_ch.valid) begin
          u <= in_ch.data;
          if (in_ch.data.action) begin
            res <= '0;
            state <= T_OUT;
          end else if (!armed) begin
            if (in_ch.data.view_ready) armed <= 1'b1;
          end else state <= T_WALK;
        end
        T_WALK: if (bdone && adone) state <= T_MUL;
        T_MUL: begin
          c <= prod >>> 12;  // floor, dropping the 12 fraction bits of spread_fraction
          state <= T_RES;
        end
        T_RES: begin
          if (r_sel > 66'sh7FFFFFFFFFFF) res <= 48'sh7FFFFFFFFFFF;
          else if (r_sel < -66'sh800000000000) res <= 48'sh800000000000;
          else res <= r_sel[PriceW-1:0];
          state <= T_OUT;
        end
        T_OUT: if (out_ch.ready) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/qlca_checker.sv =====
// Port-level checker for the amplifier core, bound into the amplifier core.
// Uses the assertion macros header.
`include "quote_level_change_amplifier_core_macros.svh"
module qlca_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [47:0] indicator
);
  `QLCA_ASSERT_IMP(a_excl, clk, rst, out_valid, !in_ready)
  `QLCA_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(indicator))
  `QLCA_ASSERT_NXT(a_busy, clk, rst, in_valid && in_ready, !in_ready || !out_valid)
endmodule

bind quote_level_change_amplifier_core qlca_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .indicator(out_ch.data.indicator));
